/* src/spcmf_pkg.sv */
// Shared types, constants and CRC helper for the steering P-control Modbus frame block.
// Used by the channel interfaces and every module under src.
// No dependencies.
package spcmf_pkg;

  // Widths of the payload fields and the configuration port.
  localparam int unsigned PosW     = 16;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LimitW   = 15;

  // Configuration register indexes; code 7 selects nothing.
  typedef enum logic [CfgIdxW-1:0] {
    REG_P_GAIN        = 3'd0,
    REG_CONTROL_LIMIT = 3'd1,
    REG_DEADZONE_BASE = 3'd2,
    REG_RATIO_RIGHT   = 3'd3,
    REG_RATIO_LEFT    = 3'd4,
    REG_DRIVE_BIAS    = 3'd5,
    REG_DRIVE_LIMIT   = 3'd6
  } cfg_reg_e;

  // Configuration register file as seen by the datapath.
  typedef struct packed {
    logic [15:0]       p_gain;
    logic [LimitW-1:0] control_limit;
    logic [15:0]       deadzone_base;
    logic [15:0]       ratio_right;
    logic [15:0]       ratio_left;
    logic [LimitW-1:0] drive_bias;
    logic [LimitW-1:0] drive_limit;
  } cfg_t;

  // Reset values of the configuration registers and the dead zone.
  localparam logic [15:0]       PGainRst        = 16'd384;
  localparam logic [LimitW-1:0] ControlLimitRst = 15'd1500;
  localparam logic [15:0]       DeadzoneBaseRst = 16'd20;
  localparam logic [15:0]       RatioRightRst   = 16'd4588;
  localparam logic [15:0]       RatioLeftRst    = 16'd2621;
  localparam logic [LimitW-1:0] DriveBiasRst    = 15'd300;
  localparam logic [LimitW-1:0] DriveLimitRst   = 15'd2000;
  localparam logic [15:0]       DeadZoneRst     = 16'd10;

  // Target thresholds that pick the dead zone widening ratio.
  localparam logic signed [PosW-1:0] TgtHighThresh = 16'sd100;
  localparam logic signed [PosW-1:0] TgtLowThresh  = -16'sd100;

  // Fixed frame header: slave address, write-single-register, register 0x0040.
  localparam logic [ByteW-1:0] SlaveAddr = 8'h01;
  localparam logic [ByteW-1:0] FuncWrite = 8'h06;
  localparam logic [ByteW-1:0] RegAddrHi = 8'h00;
  localparam logic [ByteW-1:0] RegAddrLo = 8'h40;

  // Byte positions within a frame.
  localparam logic [2:0] PosSlave   = 3'd0;
  localparam logic [2:0] PosFunc    = 3'd1;
  localparam logic [2:0] PosRegHi   = 3'd2;
  localparam logic [2:0] PosRegLo   = 3'd3;
  localparam logic [2:0] PosValueHi = 3'd4;
  localparam logic [2:0] PosValueLo = 3'd5;
  localparam logic [2:0] PosCrcLo   = 3'd6;
  localparam logic [2:0] PosCrcHi   = 3'd7;

  // Modbus CRC-16, reflected polynomial, initial value all ones.
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Folds one byte into the running CRC, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // CRC after the four header bytes, which never change.
  localparam logic [15:0] CrcPreset =
    crc_byte(crc_byte(crc_byte(crc_byte(CrcInit, SlaveAddr), FuncWrite), RegAddrHi), RegAddrLo);

endpackage

/* src/spcmf_ifs.sv */
// Valid/ready channel interfaces: input item, frame byte output and configuration writes.
// Depends on spcmf_pkg for field widths.

// Input channel: target and measured steering position.
interface spcmf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spcmf_pkg::PosW-1:0]    target_position;
  logic signed [spcmf_pkg::PosW-1:0]    measured_position;

  modport source (output valid, output target_position, output measured_position,
                  input ready);
  modport sink (input valid, input target_position, input measured_position,
                output ready);
endinterface

// Output channel: one frame byte per item.
interface spcmf_out_if;
  logic                         valid;
  logic                         ready;
  logic [spcmf_pkg::ByteW-1:0]  frame_byte;
  logic                         frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// Configuration write channel: register index and write data.
interface spcmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spcmf_pkg::CfgIdxW-1:0]   index;
  logic [spcmf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/steering_p_control_modbus_frame_top.sv */
// Top level of the steering P-control Modbus frame block: configuration registers and wiring.
// Depends on spcmf_pkg, spcmf_ifs, spcmf_front, spcmf_queue and spcmf_back.
//
//   channel  direction  payload                                  item
//   in_i     sink       target_position, measured_position       one position pair
//   out_o    source     frame_byte, frame_last                   one frame byte
//   cfg_i    sink       index, data                              one register write
//
// Each input item produces eight output items, one per cycle while out_o.ready is high, so the
// frame sequencer's byte rate sets the sustained input rate.
// An accepted input passes stages A to E and the queue before the sequencer sends its first byte.
// The five-stage front end and the sequencer are parted by a QUEUE_DEPTH-entry queue, so
// input keeps flowing while a frame waits on out_o.ready; the front stalls only when full.
// Reset restores cfg registers and the dead zone at once; no clearing pass. cfg_i is always ready.
module steering_p_control_modbus_frame_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  spcmf_in_if.sink       in_i,
  spcmf_out_if.source    out_o,
  spcmf_cfg_if.sink      cfg_i
);

  spcmf_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  // Configuration register file; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p_gain        <= spcmf_pkg::PGainRst;
      cfg_q.control_limit <= spcmf_pkg::ControlLimitRst;
      cfg_q.deadzone_base <= spcmf_pkg::DeadzoneBaseRst;
      cfg_q.ratio_right   <= spcmf_pkg::RatioRightRst;
      cfg_q.ratio_left    <= spcmf_pkg::RatioLeftRst;
      cfg_q.drive_bias    <= spcmf_pkg::DriveBiasRst;
      cfg_q.drive_limit   <= spcmf_pkg::DriveLimitRst;
    end else if (cfg_i.valid) begin
      case (spcmf_pkg::cfg_reg_e'(cfg_i.index))
        spcmf_pkg::REG_P_GAIN:        cfg_q.p_gain        <= cfg_i.data;
        spcmf_pkg::REG_CONTROL_LIMIT: cfg_q.control_limit <= cfg_i.data[14:0];
        spcmf_pkg::REG_DEADZONE_BASE: cfg_q.deadzone_base <= cfg_i.data;
        spcmf_pkg::REG_RATIO_RIGHT:   cfg_q.ratio_right   <= cfg_i.data;
        spcmf_pkg::REG_RATIO_LEFT:    cfg_q.ratio_left    <= cfg_i.data;
        spcmf_pkg::REG_DRIVE_BIAS:    cfg_q.drive_bias    <= cfg_i.data[14:0];
        spcmf_pkg::REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  logic                          push_valid, push_ready;
  logic [spcmf_pkg::ValueW-1:0]  push_value;
  logic                          pop_valid, pop_ready;
  logic [spcmf_pkg::ValueW-1:0]  pop_value;

  // Control path computing the drive value.
  spcmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_value_o (push_value),
    .push_ready_i (push_ready)
  );

  // Decoupling queue of drive values.
  spcmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_value),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_value)
  );

  // Frame byte sequencer.
  spcmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_value),
    .out_o       (out_o)
  );

endmodule

/* src/spcmf_front.sv */
// Front end: accepts position items and computes the signed drive value in five stages.
// Holds the dead zone state. Depends on spcmf_pkg and spcmf_ifs.
module spcmf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spcmf_pkg::cfg_t                 cfg_i,
  spcmf_in_if.sink                        in_i,
  output logic                            push_valid_o,
  output logic [spcmf_pkg::ValueW-1:0]    push_value_o,
  input  logic                            push_ready_i
);

  // Last stage registers, declared first since the pipeline enable reads them.
  logic                          e_valid_q;
  logic [spcmf_pkg::ValueW-1:0]  e_value_q;

  // The whole pipeline moves together; it holds only when the last stage cannot push.
  logic en;
  assign en = !e_valid_q || push_ready_i;
  assign in_i.ready = en;

  // Stage A: captured input positions.
  logic                                 a_valid_q;
  logic signed [spcmf_pkg::PosW-1:0]    a_tgt_q, a_meas_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_i.valid) begin
      a_tgt_q  <= in_i.target_position;
      a_meas_q <= in_i.measured_position;
    end
  end

  // Stage B: error sign and magnitude, target magnitude and the selected ratio.
  logic [16:0] err_w, amag_w, tgt_ext_w, tmag_w;
  logic [15:0] ratio_w;

  assign err_w     = {a_tgt_q[15], a_tgt_q} - {a_meas_q[15], a_meas_q};
  assign amag_w    = err_w[16] ? (17'd0 - err_w) : err_w;
  assign tgt_ext_w = {a_tgt_q[15], a_tgt_q};
  assign tmag_w    = a_tgt_q[15] ? (17'd0 - tgt_ext_w) : tgt_ext_w;

  always_comb begin
    if (a_tgt_q < spcmf_pkg::TgtLowThresh) begin
      ratio_w = cfg_i.ratio_right;
    end else if (a_tgt_q > spcmf_pkg::TgtHighThresh) begin
      ratio_w = cfg_i.ratio_left;
    end else begin
      ratio_w = 16'd0;
    end
  end

  logic        b_valid_q, b_neg_q;
  logic [15:0] b_amag_q, b_tmag_q, b_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_neg_q   <= err_w[16];
      b_amag_q  <= amag_w[15:0];
      b_tmag_q  <= tmag_w[15:0];
      b_ratio_q <= ratio_w;
    end
  end

  // Stage C: gain product and dead zone widening product.
  logic        c_valid_q, c_neg_q;
  logic [15:0] c_amag_q;
  logic [31:0] c_gprod_q, c_rprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_neg_q   <= b_neg_q;
      c_amag_q  <= b_amag_q;
      c_gprod_q <= b_amag_q * cfg_i.p_gain;
      c_rprod_q <= b_tmag_q * b_ratio_q;
    end
  end

  // Stage D: dead zone test, speed clamp and dead zone reload.
  logic                              outside_w;
  logic [16:0]                       dz_sum_w;
  logic [15:0]                       dz_new_w;
  logic [spcmf_pkg::LimitW-1:0]      speed_w;
  logic [15:0]                       dead_zone_q;

  assign outside_w = c_amag_q > dead_zone_q;
  assign dz_sum_w  = {1'b0, cfg_i.deadzone_base} + {1'b0, c_rprod_q[31:16]};
  assign dz_new_w  = dz_sum_w[16] ? 16'hFFFF : dz_sum_w[15:0];

  always_comb begin
    if (!outside_w) begin
      speed_w = '0;
    end else if (c_gprod_q[31:8] > {9'd0, cfg_i.control_limit}) begin
      speed_w = cfg_i.control_limit;
    end else begin
      speed_w = c_gprod_q[22:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= spcmf_pkg::DeadZoneRst;
    end else if (en && c_valid_q && !outside_w) begin
      dead_zone_q <= dz_new_w;
    end
  end

  logic                          d_valid_q, d_neg_q;
  logic [spcmf_pkg::LimitW-1:0]  d_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_neg_q   <= c_neg_q;
      d_speed_q <= speed_w;
    end
  end

  // Stage E: bias away from zero, drive clamp and sign.
  logic [15:0] biased_w, drive_mag_w, value_w;

  always_comb begin
    if (d_speed_q == '0) begin
      biased_w = 16'd0;
    end else begin
      biased_w = {1'b0, d_speed_q} + {1'b0, cfg_i.drive_bias};
    end
    if (biased_w > {1'b0, cfg_i.drive_limit}) begin
      drive_mag_w = {1'b0, cfg_i.drive_limit};
    end else begin
      drive_mag_w = biased_w;
    end
    value_w = d_neg_q ? (16'd0 - drive_mag_w) : drive_mag_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_value_q <= value_w;
    end
  end

  assign push_valid_o = e_valid_q;
  assign push_value_o = e_value_q;

  // The dead zone only changes when an item leaves stage C.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(en && c_valid_q) |-> $stable(dead_zone_q))
    else $error("dead zone changed without an item in the test stage");

  // A stalled pipeline keeps its pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q && !push_ready_i |=> e_valid_q && $stable(e_value_q))
    else $error("front result lost during stall");

endmodule

/* src/spcmf_queue.sv */
// Short FIFO of drive values between the front end and the frame sequencer.
// Depends on spcmf_pkg.
module spcmf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_valid_i,
  output logic                            push_ready_o,
  input  logic [spcmf_pkg::ValueW-1:0]    push_data_i,
  output logic                            pop_valid_o,
  input  logic                            pop_ready_i,
  output logic [spcmf_pkg::ValueW-1:0]    pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

  logic [spcmf_pkg::ValueW-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]              count_q;
  logic                         push, pop;

  assign push_ready_o = count_q != FullCnt;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Fill count tracks pushes and pops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue overfilled");

endmodule

/* src/spcmf_back.sv */
// Frame sequencer: sends one eight-byte Modbus write frame per drive value, CRC on the fly.
// Depends on spcmf_pkg and spcmf_ifs.
module spcmf_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  logic [spcmf_pkg::ValueW-1:0]    pop_data_i,
  spcmf_out_if.source                     out_o
);

  logic                          busy_q;
  logic [2:0]                    pos_q;
  logic [spcmf_pkg::ValueW-1:0]  value_q;
  logic [15:0]                   crc_q;
  logic                          fire, last_fire, pop;

  assign fire        = busy_q && out_o.ready;
  assign last_fire   = fire && (pos_q == spcmf_pkg::PosCrcHi);
  assign pop_ready_o = !busy_q || last_fire;
  assign pop         = pop_valid_i && pop_ready_o;

  // Byte select for the current frame position.
  always_comb begin
    case (pos_q)
      spcmf_pkg::PosSlave:   out_o.frame_byte = spcmf_pkg::SlaveAddr;
      spcmf_pkg::PosFunc:    out_o.frame_byte = spcmf_pkg::FuncWrite;
      spcmf_pkg::PosRegHi:   out_o.frame_byte = spcmf_pkg::RegAddrHi;
      spcmf_pkg::PosRegLo:   out_o.frame_byte = spcmf_pkg::RegAddrLo;
      spcmf_pkg::PosValueHi: out_o.frame_byte = value_q[15:8];
      spcmf_pkg::PosValueLo: out_o.frame_byte = value_q[7:0];
      spcmf_pkg::PosCrcLo:   out_o.frame_byte = crc_q[7:0];
      spcmf_pkg::PosCrcHi:   out_o.frame_byte = crc_q[15:8];
      default:               out_o.frame_byte = spcmf_pkg::SlaveAddr;
    endcase
  end

  assign out_o.valid      = busy_q;
  assign out_o.frame_last = pos_q == spcmf_pkg::PosCrcHi;

  // Frame control: load a new value at frame start, step on each sent byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= spcmf_pkg::PosSlave;
    end else if (pop) begin
      busy_q <= 1'b1;
      pos_q  <= spcmf_pkg::PosSlave;
    end else if (fire) begin
      if (last_fire) begin
        busy_q <= 1'b0;
      end
      pos_q <= pos_q + 3'd1;
    end
  end

  // The CRC starts from the header preset and absorbs the two value bytes as they go out.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      value_q <= pop_data_i;
      crc_q   <= spcmf_pkg::CrcPreset;
    end else if (fire && pos_q == spcmf_pkg::PosValueHi) begin
      crc_q <= spcmf_pkg::crc_byte(crc_q, value_q[15:8]);
    end else if (fire && pos_q == spcmf_pkg::PosValueLo) begin
      crc_q <= spcmf_pkg::crc_byte(crc_q, value_q[7:0]);
    end
  end

  // A byte sent mid-frame moves to the next position with the frame still open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pos_q != spcmf_pkg::PosCrcHi |=> busy_q && pos_q == $past(pos_q) + 3'd1)
    else $error("frame position did not advance");

  // A new value always starts a frame at the first byte with the header CRC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> busy_q && pos_q == spcmf_pkg::PosSlave && crc_q == spcmf_pkg::CrcPreset)
    else $error("frame did not restart cleanly");

endmodule
